@@ hdl/spvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package spvm_pkg;

	typedef enum logic [2:0] {
		CMD_MIX    = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_DEFINE = 3'd2,
		CMD_EFFECT = 3'd3,
		CMD_MUSIC  = 3'd4,
		CMD_STOP   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EFFECT,
		ST_WALK,
		ST_DRAIN,
		ST_SCALE,
		ST_OUT
	} state_t;

	localparam logic [8:0] GAIN_UNITY = 9'd256;
	localparam logic [6:0] NO_MUSIC = 7'd127;
	localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
	localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

endpackage
`default_nettype wire

@@ hdl/spvm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/sample_playback_voice_mixer_top.sv @@
// Mix tick: the walk visits one voice a cycle and reads the sample RAM through the s1 address
// and s2 RAM read stages before accumulating, then scales the sum and outputs it.
// Play effect reads the effect table RAM, then picks a voice; write, define, music and stop act at acceptance.
// One transaction at a time; the result register lets the next transaction in while it waits.
// Reset: all voices idle, effect table absent, no music chosen, gain unity; sample RAM
// keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sample_playback_voice_mixer_top #(
	parameter int VOICE_COUNT  = 8,
	parameter int EFFECT_SLOTS = 32,
	parameter int SAMPLE_DEPTH = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               gain_wr_en,
	input  wire logic [8:0]         gain_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         cmd,
	input  wire logic [15:0]        address,
	input  wire logic signed [15:0] sample_value,
	input  wire logic [5:0]         sound_index,
	input  wire logic [15:0]        length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      mixed_sample
);

	localparam int VW     = $clog2(VOICE_COUNT);
	localparam int EAW    = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
	localparam int SAW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int ACC_W  = 16 + VW;
	localparam int PROD_W = ACC_W + 10;
	localparam int QW     = PROD_W - 8;

	// reduce a 16-bit address into the store; quotient stays below 256
	function automatic logic [SAW-1:0] store_addr(input logic [15:0] a);
		logic [31:0] r;
		logic [31:0] d;
		r = {16'd0, a};
		for (int i = 7; i >= 0; i--) begin
			d = 32'(SAMPLE_DEPTH) << i;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[SAW-1:0];
	endfunction

	spvm_pkg::state_t state_q, state_d;

	logic in_acc;
	logic [8:0] gain_q;
	logic [6:0] music_q;

	logic             active_q [VOICE_COUNT];
	logic             loop_q   [VOICE_COUNT];
	logic [15:0]      base_q   [VOICE_COUNT];
	logic [15:0]      len_q    [VOICE_COUNT];
	logic [15:0]      pos_q    [VOICE_COUNT];

	logic             eff_valid_q [EFFECT_SLOTS];
	logic             eff_ok_q;
	logic             eff_in_range;
	logic [EAW-1:0]   eff_idx;
	logic [31:0]      eff_rdata;

	logic             pick_found;
	logic [VW-1:0]    pick_v;

	logic [VW-1:0]    vcnt_q;
	logic             walk_last;
	logic             walk_hit;
	logic             walk_ended;
	logic [15:0]      walk_pos;

	logic [15:0]      addr_s1;
	logic             hit_s1, vld_s1, last_s1;
	logic             hit_s2, last_s2;
	logic [15:0]      store_rdata;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] biased;
	logic [QW-1:0]            shifted;
	logic signed [15:0]       sat;
	logic                     out_free;

	logic             store_we;
	logic [SAW-1:0]   store_waddr;
	logic [SAW-1:0]   store_raddr;

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign eff_in_range = {26'd0, sound_index} < 32'(EFFECT_SLOTS);
	assign eff_idx = sound_index[EAW-1:0];

	assign store_we = in_acc && (cmd == spvm_pkg::CMD_WRITE);
	assign store_waddr = store_addr(address);
	assign store_raddr = store_addr(addr_s1);

	spvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (sample_value),
		.re    (vld_s1 && hit_s1),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	spvm_ram #(.WIDTH(32), .DEPTH(EFFECT_SLOTS)) u_effects (
		.clk   (clk),
		.we    (in_acc && (cmd == spvm_pkg::CMD_DEFINE) && eff_in_range),
		.waddr (eff_idx),
		.wdata ({address, length}),
		.re    (in_acc && (cmd == spvm_pkg::CMD_EFFECT)),
		.raddr (eff_idx),
		.rdata (eff_rdata)
	);

	// first idle voice above the music voice
	always_comb begin
		pick_found = 1'b0;
		pick_v = '0;
		for (int v = VOICE_COUNT - 1; v >= 1; v--) begin
			if (!active_q[v]) begin
				pick_found = 1'b1;
				pick_v = VW'(v);
			end
		end
	end

	assign walk_last = (vcnt_q == VW'(VOICE_COUNT - 1));
	assign walk_ended = pos_q[vcnt_q] >= len_q[vcnt_q];
	assign walk_pos = walk_ended ? 16'd0 : pos_q[vcnt_q];
	assign walk_hit = active_q[vcnt_q] && (!walk_ended || loop_q[vcnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = (state_q != spvm_pkg::ST_IDLE);
		case (state_q)
			spvm_pkg::ST_IDLE: begin
				if (in_acc && cmd == spvm_pkg::CMD_MIX) begin
					state_d = spvm_pkg::ST_WALK;
				end else if (in_acc && cmd == spvm_pkg::CMD_EFFECT) begin
					state_d = spvm_pkg::ST_EFFECT;
				end
			end
			spvm_pkg::ST_EFFECT: state_d = spvm_pkg::ST_IDLE;
			spvm_pkg::ST_WALK: begin
				if (walk_last) begin
					state_d = spvm_pkg::ST_DRAIN;
				end
			end
			spvm_pkg::ST_DRAIN: begin
				if (last_s2) begin
					state_d = spvm_pkg::ST_SCALE;
				end
			end
			spvm_pkg::ST_SCALE: state_d = spvm_pkg::ST_OUT;
			spvm_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = spvm_pkg::ST_IDLE;
				end
			end
			default: state_d = spvm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= spvm_pkg::GAIN_UNITY;
		end else if (gain_wr_en) begin
			gain_q <= gain_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_q <= spvm_pkg::NO_MUSIC;
			eff_ok_q <= 1'b0;
			for (int e = 0; e < EFFECT_SLOTS; e++) begin
				eff_valid_q[e] <= 1'b0;
			end
		end else if (in_acc) begin
			if (cmd == spvm_pkg::CMD_MUSIC) begin
				music_q <= {1'b0, sound_index};
			end
			if (cmd == spvm_pkg::CMD_DEFINE && eff_in_range) begin
				eff_valid_q[eff_idx] <= 1'b1;
			end
			eff_ok_q <= eff_in_range && eff_valid_q[eff_idx];
		end
	end

	// voice state: commands act at acceptance, effect pick and walk act later
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				active_q[v] <= 1'b0;
				loop_q[v] <= 1'b0;
				base_q[v] <= '0;
				len_q[v] <= '0;
				pos_q[v] <= '0;
			end
		end else begin
			if (in_acc && cmd == spvm_pkg::CMD_STOP) begin
				for (int v = 0; v < VOICE_COUNT; v++) begin
					active_q[v] <= 1'b0;
				end
			end
			if (in_acc && cmd == spvm_pkg::CMD_MUSIC && {1'b0, sound_index} != music_q) begin
				active_q[0] <= (length != 16'd0);
				loop_q[0] <= 1'b1;
				base_q[0] <= address;
				len_q[0] <= length;
				pos_q[0] <= 16'd0;
			end
			if (state_q == spvm_pkg::ST_EFFECT && eff_ok_q && eff_rdata[15:0] != 16'd0
					&& pick_found) begin
				active_q[pick_v] <= 1'b1;
				loop_q[pick_v] <= 1'b0;
				base_q[pick_v] <= eff_rdata[31:16];
				len_q[pick_v] <= eff_rdata[15:0];
				pos_q[pick_v] <= 16'd0;
			end
			if (state_q == spvm_pkg::ST_WALK) begin
				if (active_q[vcnt_q] && !walk_hit) begin
					active_q[vcnt_q] <= 1'b0;
				end
				if (walk_hit) begin
					pos_q[vcnt_q] <= walk_pos + 16'd1;
				end
			end
		end
	end

	// walk pipeline: s1 address, s2 RAM read, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
			last_s1 <= 1'b0;
			hit_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			if (state_q == spvm_pkg::ST_WALK) begin
				vcnt_q <= walk_last ? '0 : vcnt_q + VW'(1);
			end
			vld_s1 <= (state_q == spvm_pkg::ST_WALK);
			hit_s1 <= (state_q == spvm_pkg::ST_WALK) && walk_hit;
			last_s1 <= (state_q == spvm_pkg::ST_WALK) && walk_last;
			hit_s2 <= vld_s1 && hit_s1;
			last_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= base_q[vcnt_q] + walk_pos;
		if (in_acc && cmd == spvm_pkg::CMD_MIX) begin
			acc_q <= '0;
		end else if (hit_s2) begin
			acc_q <= acc_q + {{(ACC_W - 16){store_rdata[15]}}, store_rdata};
		end
		if (state_q == spvm_pkg::ST_SCALE) begin
			prod_q <= PROD_W'(acc_q * $signed({1'b0, gain_q}));
		end
	end

	// divide by 256 toward zero, then saturate
	assign biased = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
	assign shifted = biased[PROD_W-1:8];
	always_comb begin
		if (shifted[QW-1:15] == '0 || shifted[QW-1:15] == '1) begin
			sat = $signed(shifted[15:0]);
		end else if (shifted[QW-1]) begin
			sat = spvm_pkg::SAMPLE_MIN;
		end else begin
			sat = spvm_pkg::SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == spvm_pkg::ST_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spvm_pkg::ST_OUT && out_free) begin
			mixed_sample <= sat;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/sample_playback_voice_mixer_top_test.sv @@
`timescale 1ns / 1ps
module sample_playback_voice_mixer_top_test;

	localparam int VOICES = 8;
	localparam int FX_SLOTS = 32;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int SETTLE_CYCLES = VOICES + 8;

	logic clk;
	logic arst_n;
	logic gain_wr_en;
	logic [8:0] gain_wr_data;
	logic in_valid;
	logic in_stall;
	logic [2:0] cmd;
	logic [15:0] address;
	logic signed [15:0] sample_value;
	logic [5:0] sound_index;
	logic [15:0] length;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] mixed_sample;

	sample_playback_voice_mixer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.gain_wr_en(gain_wr_en),
		.gain_wr_data(gain_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.address(address),
		.sample_value(sample_value),
		.sound_index(sound_index),
		.length(length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mixed_sample(mixed_sample)
	);

	// mirror of the mixer state
	bit voice_on [VOICES];
	bit voice_loops [VOICES];
	logic [15:0] voice_base [VOICES];
	logic [15:0] voice_len [VOICES];
	logic [15:0] voice_pos [VOICES];
	logic [15:0] pcm_store [0:65535];
	bit pcm_written [0:65535];
	logic [15:0] fx_base [FX_SLOTS];
	logic [15:0] fx_len [FX_SLOTS];
	logic [6:0] music_track;
	logic [8:0] gain_now;

	logic signed [15:0] mix_expected_q [$];
	int errors;
	int items_sent;
	bit gaps_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic void silence_voice(input int v);
		voice_on[v] = 1'b0;
		voice_loops[v] = 1'b0;
		voice_base[v] = '0;
		voice_len[v] = '0;
		voice_pos[v] = '0;
	endfunction

	function automatic logic signed [15:0] mix_predict();
		int total;
		int scaled;
		int v;
		logic [15:0] rd;
		shortint s;
		total = 0;
		for (v = 0; v < VOICES; v++) begin
			if (voice_on[v] && voice_pos[v] >= voice_len[v]) begin
				if (voice_loops[v])
					voice_pos[v] = '0;
				else
					silence_voice(v);
			end
			if (voice_on[v]) begin
				rd = voice_base[v] + voice_pos[v];
				s = pcm_store[rd];
				total += s;
				voice_pos[v] = voice_pos[v] + 16'd1;
			end
		end
		scaled = (total * int'(gain_now)) / 256;
		if (scaled < -32768)
			scaled = -32768;
		if (scaled > 32767)
			scaled = 32767;
		return 16'(scaled);
	endfunction

	function automatic bit predict_item(input logic [2:0] c, input logic [15:0] a,
			input logic [15:0] sv, input logic [5:0] idx, input logic [15:0] len,
			output logic signed [15:0] mixed);
		int v;
		mixed = '0;
		case (c)
			spvm_pkg::CMD_MIX: begin
				mixed = mix_predict();
				return 1'b1;
			end
			spvm_pkg::CMD_WRITE: begin
				pcm_store[a] = sv;
				pcm_written[a] = 1'b1;
			end
			spvm_pkg::CMD_DEFINE: begin
				if (idx < FX_SLOTS) begin
					fx_base[idx] = a;
					fx_len[idx] = len;
				end
			end
			spvm_pkg::CMD_EFFECT: begin
				if (idx < FX_SLOTS && fx_len[idx] != 0) begin
					for (v = 1; v < VOICES; v++) begin
						if (!voice_on[v]) begin
							voice_on[v] = 1'b1;
							voice_loops[v] = 1'b0;
							voice_base[v] = fx_base[idx];
							voice_len[v] = fx_len[idx];
							voice_pos[v] = '0;
							break;
						end
					end
				end
			end
			spvm_pkg::CMD_MUSIC: begin
				if ({1'b0, idx} != music_track) begin
					music_track = {1'b0, idx};
					silence_voice(0);
					if (len != 0) begin
						voice_on[0] = 1'b1;
						voice_loops[0] = 1'b1;
						voice_base[0] = a;
						voice_len[0] = len;
					end
				end
			end
			spvm_pkg::CMD_STOP: begin
				for (v = 0; v < VOICES; v++)
					silence_voice(v);
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// address the voice will read on the next tick, if any
	function automatic bit next_read(input int v, output logic [15:0] rd);
		rd = '0;
		if (!voice_on[v])
			return 1'b0;
		if (voice_pos[v] >= voice_len[v]) begin
			if (!voice_loops[v])
				return 1'b0;
			rd = voice_base[v];
		end else begin
			rd = voice_base[v] + voice_pos[v];
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [15:0] got,
			input logic signed [15:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic [2:0] c, input logic [15:0] a, input logic [15:0] sv,
			input logic [5:0] idx, input logic [15:0] len);
		logic signed [15:0] mixed;
		if (gaps_on && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		address <= a;
		sample_value <= sv;
		sound_index <= idx;
		length <= len;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (predict_item(c, a, sv, idx, len, mixed))
			mix_expected_q.push_back(mixed);
	endtask

	// fill any store entry a voice is about to read, then tick
	task automatic mix_tick();
		logic [15:0] rd;
		int v;
		for (v = 0; v < VOICES; v++) begin
			if (next_read(v, rd) && !pcm_written[rd])
				send_item(spvm_pkg::CMD_WRITE, rd, rnd16(), 6'($urandom), rnd16());
		end
		send_item(spvm_pkg::CMD_MIX, rnd16(), rnd16(), 6'($urandom), rnd16());
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (mix_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_output_gain(input logic [8:0] g);
		wait_results_done();
		gain_wr_en <= 1'b1;
		gain_wr_data <= g;
		@(posedge clk);
		gain_wr_en <= 1'b0;
		gain_now = g;
	endtask

	function automatic logic [5:0] pick_slot();
		if ($urandom_range(9) == 0)
			return 6'($urandom_range(32, 63));
		return 6'($urandom_range(0, 31));
	endfunction

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 15)
			return rnd16();
		return 16'($urandom_range(1, 16));
	endfunction

	task automatic random_item();
		int pick;
		logic [5:0] track;
		pick = $urandom_range(99);
		track = ($urandom_range(9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom);
		if (pick < 42)
			mix_tick();
		else if (pick < 52)
			send_item(spvm_pkg::CMD_WRITE, rnd16(), rnd16(), 6'($urandom), rnd16());
		else if (pick < 65)
			send_item(spvm_pkg::CMD_DEFINE, rnd16(), rnd16(), pick_slot(), pick_length());
		else if (pick < 84)
			send_item(spvm_pkg::CMD_EFFECT, rnd16(), rnd16(), pick_slot(), rnd16());
		else if (pick < 93)
			send_item(spvm_pkg::CMD_MUSIC, rnd16(), rnd16(), track, pick_length());
		else if (pick < 97)
			send_item(spvm_pkg::CMD_STOP, rnd16(), rnd16(), 6'($urandom), rnd16());
		else
			send_item(pick[0] ? CMD_SPARE_6 : CMD_SPARE_7, rnd16(), rnd16(), 6'($urandom),
				rnd16());
	endtask

	task automatic test_special_cases();
		// nothing playing gives silence
		mix_tick();
		send_item(spvm_pkg::CMD_WRITE, 16'h0100, 16'h7FFF, 6'd0, 16'd0);
		send_item(spvm_pkg::CMD_DEFINE, 16'h0100, 16'h0000, 6'd1, 16'd2);
		// seven voices take it, the eighth request finds none idle
		repeat (8) send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd1, 16'd0);
		send_item(spvm_pkg::CMD_MUSIC, 16'h0100, 16'h0000, 6'd0, 16'd1);
		// redefining a playing slot must not touch the voices
		send_item(spvm_pkg::CMD_DEFINE, 16'h4000, 16'h0000, 6'd1, 16'hFFFF);
		mix_tick();
		mix_tick();
		mix_tick();
		send_item(spvm_pkg::CMD_MUSIC, 16'hFFFF, 16'h0000, 6'd0, 16'd5);
		send_item(spvm_pkg::CMD_STOP, 16'h0000, 16'h0000, 6'd0, 16'd0);
		// effect that wraps past the top of the store
		send_item(spvm_pkg::CMD_WRITE, 16'hFFFF, 16'h8000, 6'd0, 16'd0);
		send_item(spvm_pkg::CMD_DEFINE, 16'hFFFF, 16'h0000, 6'd31, 16'd2);
		send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd31, 16'd0);
		send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd31, 16'd0);
		send_item(spvm_pkg::CMD_DEFINE, 16'h2222, 16'h0000, 6'd40, 16'd9);
		send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd63, 16'd0);
		send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd5, 16'd0);
		mix_tick();
		mix_tick();
		// zero-length music takes the track number but leaves voice 0 idle
		send_item(spvm_pkg::CMD_MUSIC, 16'h1234, 16'h0000, 6'd63, 16'd0);
		send_item(spvm_pkg::CMD_MUSIC, 16'h0000, 16'h0000, 6'd63, 16'hFFFF);
		send_item(CMD_SPARE_6, 16'hFFFF, 16'hFFFF, 6'h3F, 16'hFFFF);
		send_item(CMD_SPARE_7, 16'hFFFF, 16'hFFFF, 6'h3F, 16'hFFFF);
		mix_tick();
		send_item(spvm_pkg::CMD_STOP, 16'hFFFF, 16'hFFFF, 6'h3F, 16'hFFFF);
		mix_tick();
	endtask

	task automatic test_gain_settings();
		logic [8:0] gains [5] = '{9'd0, 9'd1, 9'd128, 9'd255, spvm_pkg::GAIN_UNITY};
		int g;
		send_item(spvm_pkg::CMD_DEFINE, rnd16(), 16'h0000, 6'd3, 16'd20);
		send_item(spvm_pkg::CMD_MUSIC, rnd16(), 16'h0000, 6'd10, 16'd6);
		for (g = 0; g < 5; g++) begin
			set_output_gain(gains[g]);
			send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd3, 16'd0);
			send_item(spvm_pkg::CMD_EFFECT, 16'h0000, 16'h0000, 6'd3, 16'd0);
			repeat (4) mix_tick();
		end
	endtask

	task automatic test_random_traffic(input int count);
		int start;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < count) begin
			random_item();
			// hold off until the pipeline is empty once mid-phase
			if (!paused && items_sent - start >= count / 2) begin
				wait_results_done();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_steady_stream(input int count);
		int start;
		wait_results_done();
		gaps_on = 1'b0;
		start = items_sent;
		while (items_sent - start < count)
			random_item();
		wait_results_done();
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (mix_expected_q.size() == 0) begin
				report_mismatch("mixed_sample with none pending", mixed_sample, 16'sd0);
			end else begin
				want = mix_expected_q.pop_front();
				if (mixed_sample !== want)
					report_mismatch("mixed_sample", mixed_sample, want);
			end
		end
		out_stall <= gaps_on && ($urandom_range(99) < 35);
	end

	initial begin
		int v;
		errors = 0;
		items_sent = 0;
		gaps_on = 1'b1;
		arst_n <= 1'b0;
		gain_wr_en <= 1'b0;
		gain_wr_data <= '0;
		in_valid <= 1'b0;
		cmd <= spvm_pkg::CMD_MIX;
		address <= '0;
		sample_value <= '0;
		sound_index <= '0;
		length <= '0;
		out_stall <= 1'b0;
		for (v = 0; v < VOICES; v++)
			silence_voice(v);
		for (v = 0; v < FX_SLOTS; v++) begin
			fx_base[v] = '0;
			fx_len[v] = '0;
		end
		music_track = spvm_pkg::NO_MUSIC;
		gain_now = spvm_pkg::GAIN_UNITY;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_gain_settings();
		set_output_gain(9'($urandom_range(0, 256)));
		test_random_traffic(230);
		set_output_gain(spvm_pkg::GAIN_UNITY);
		test_steady_stream(150);
		set_output_gain(9'($urandom_range(0, 256)));
		test_random_traffic(200);
		wait_results_done();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
